// ===== sv/dkrs_pkg.sv =====
// Shared widths, record and control types for the descending key record sorter.
package dkrs_pkg;

  localparam int KEY_W          = 32;
  localparam int TAG_W          = 16;
  localparam int RANK_W         = 6;
  localparam int MAX_ITEMS_DEF  = 16;

  // One stored record: key, tag and occupancy.
  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
    logic        [TAG_W-1:0] tag;
  } rec_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic load;   // insert the new record into the chain
    logic shift;  // move every record one cell toward the output end
  } cell_ctrl_t;

endpackage

// ===== sv/dkrs_if.sv =====
// Request channels of the sorter: record input and sorted record output.
interface dkrs_in_if import dkrs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] fitness_key;
  logic        [TAG_W-1:0] record_tag;
  logic                    final_record;

  modport source (output valid, fitness_key, record_tag, final_record, input ready);
  modport sink   (input valid, fitness_key, record_tag, final_record, output ready);
endinterface

interface dkrs_out_if import dkrs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [KEY_W-1:0]  sorted_key;
  logic        [TAG_W-1:0]  sorted_tag;
  logic        [RANK_W-1:0] rank;
  logic                     end_of_run;

  modport source (output valid, sorted_key, sorted_tag, rank, end_of_run, input ready);
  modport sink   (input valid, sorted_key, sorted_tag, rank, end_of_run, output ready);
endinterface

// ===== sv/dkrs_cell.sv =====
// One cell of the insertion chain: holds a record, inserts, shifts down or shifts out.
module dkrs_cell import dkrs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  rec_t       new_i,
  input  rec_t       upper_i,
  input  logic       upper_ge_i,
  input  rec_t       lower_i,
  output rec_t       rec_o,
  output logic       ge_o
);

  rec_t rec_q, rec_d;

  // The new record goes below this cell when this cell's key is at least as large.
  assign ge_o  = rec_q.valid && (rec_q.key >= new_i.key);
  assign rec_o = rec_q;

  always_comb begin
    rec_d = rec_q;
    if (ctrl_i.load) begin
      if (!ge_o) begin
        // Take the new record at the boundary, otherwise push down from above.
        rec_d = upper_ge_i ? new_i : upper_i;
      end
    end else if (ctrl_i.shift) begin
      rec_d = lower_i;
    end
  end

  // Only the occupancy bit is reset; key and tag hold until the cell is written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q.valid <= 1'b0;
    end else begin
      rec_q <= rec_d;
    end
  end

endmodule

// ===== sv/descending_key_record_sorter.sv =====
// Top level: systolic insertion sorter emitting records in descending key order.
// Loading takes one record request per cycle; each lands in its sorted place at once unless the chain is full.
// The first sorted record is offered the cycle after the final record is taken, then one
// record per cycle as the output accepts them; each accepted record shifts the cell chain once.
// Reset empties every cell and returns the block to loading; stored keys and tags are not cleared.
module descending_key_record_sorter import dkrs_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  dkrs_in_if.sink    in_i,
  dkrs_out_if.source out_o
);

  // Two phases: gather records, then drain them in order.
  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  localparam rec_t                 RecNone = '0;
  localparam logic [MAX_ITEMS-1:0] OneV    = 1;

  logic              state_q, state_d;
  logic [RANK_W-1:0] rank_q, rank_d;

  rec_t                 cell_rec [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] cell_ge;
  logic [MAX_ITEMS-1:0] valid_vec;

  rec_t       new_rec;
  cell_ctrl_t ctrl;
  logic       in_fire, out_fire, chain_full, last_out;

  // Handshakes. Input is taken only while loading; the output is shown only while draining.
  assign in_i.ready = (state_q == ST_LOAD);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;

  // Chain is full when the bottom cell is occupied; extra records are dropped.
  assign chain_full = cell_rec[MAX_ITEMS-1].valid;

  assign new_rec.valid = 1'b1;
  assign new_rec.key   = in_i.fitness_key;
  assign new_rec.tag   = in_i.record_tag;

  assign ctrl.load  = in_fire && !chain_full;
  assign ctrl.shift = out_fire;

  // Cell 0 holds the largest key. Occupied cells always form a prefix of the chain,
  // and equal keys stay in load order because a new record goes below its equals.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    rec_t upper_rec, lower_rec;
    logic upper_ge;

    if (i == 0) begin : g_top
      assign upper_rec = new_rec;
      assign upper_ge  = 1'b1;
    end else begin : g_mid
      assign upper_rec = cell_rec[i-1];
      assign upper_ge  = cell_ge[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_bot
      assign lower_rec = RecNone;
    end else begin : g_low
      assign lower_rec = cell_rec[i+1];
    end

    dkrs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .new_i      (new_rec),
      .upper_i    (upper_rec),
      .upper_ge_i (upper_ge),
      .lower_i    (lower_rec),
      .rec_o      (cell_rec[i]),
      .ge_o       (cell_ge[i])
    );

    assign valid_vec[i] = cell_rec[i].valid;
  end

  // Output comes straight from the head cell, which holds while the sink stalls.
  assign last_out          = !cell_rec[1].valid;
  assign out_o.valid       = (state_q == ST_EMIT);
  assign out_o.sorted_key  = cell_rec[0].key;
  assign out_o.sorted_tag  = cell_rec[0].tag;
  assign out_o.rank        = rank_q;
  assign out_o.end_of_run  = last_out;

  always_comb begin
    state_d = state_q;
    rank_d  = rank_q;
    case (state_q)
      ST_LOAD: begin
        if (in_fire && in_i.final_record) begin
          state_d = ST_EMIT;
          rank_d  = '0;
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          // Advance rank; drop back to loading after the last record leaves.
          rank_d = rank_q + RANK_W'(1);
          if (last_out) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      rank_q  <= '0;
    end else begin
      state_q <= state_d;
      rank_q  <= rank_d;
    end
  end

  // Occupied cells form a contiguous prefix.
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + OneV)) == '0)
    else $error("occupied cells are not a prefix of the chain");

  // Head of the chain never holds a smaller key than its neighbor.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_rec[1].valid |-> (cell_rec[0].key >= cell_rec[1].key))
    else $error("chain out of descending order");

  // While draining, the head cell is always occupied.
  a_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> cell_rec[0].valid)
    else $error("result offered from an empty head cell");

  // After the last record of a set leaves, the chain is empty and loading resumes.
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && last_out) |=> (in_i.ready && (valid_vec == '0)))
    else $error("chain not empty after end of run");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the descending key record sorter: directed and random record sets.
`timescale 1ns / 1ps

module testbench;
  import dkrs_pkg::*;

  localparam int DEPTH      = MAX_ITEMS_DEF;
  localparam int SETTLE     = 2 * DEPTH + 4;   // extra wait after the drain, sized from the store depth
  localparam int DRAIN_MAX  = 20000;           // cycles allowed for the last results
  localparam int HOLD_CYC   = 250;             // long receiver hold-off
  localparam int TAIL_ITEMS = 40;              // no idling once this few remain
  localparam int RAND_ITEMS = 260;

  // One record request as offered to the sorter.
  typedef struct {
    logic signed [KEY_W-1:0] key;
    logic        [TAG_W-1:0] tag;
    logic                    fin;
  } record_req_t;

  // One sorted record as the sorter should emit it.
  typedef struct {
    logic signed [KEY_W-1:0]  key;
    logic        [TAG_W-1:0]  tag;
    logic        [RANK_W-1:0] rank;
    logic                     eor;
  } sorted_rec_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dkrs_in_if  rec_in ();
  dkrs_out_if rec_out ();

  descending_key_record_sorter #(.MAX_ITEMS(DEPTH)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (rec_in),
    .out_o  (rec_out)
  );

  // Records still to offer, and sorted records still owed by the sorter.
  record_req_t record_backlog[$];
  sorted_rec_t sorted_due[$];

  // Predictor copy of the record store.
  logic signed [KEY_W-1:0] held_key [DEPTH];
  logic        [TAG_W-1:0] held_tag [DEPTH];
  int held_cnt = 0;

  int errors        = 0;
  int sets_done     = 0;
  int records_cut   = 0;
  int results_seen  = 0;
  int accepted_total;
  int gap_left;
  int stall_left;
  int hold_left;
  logic hold_rx;
  logic hold_done;
  logic tail_phase;

  // Clock and reset.
  initial begin
    rec_in.valid        = 1'b0;
    rec_in.fitness_key  = '0;
    rec_in.record_tag   = '0;
    rec_in.final_record = 1'b0;
    rec_out.ready       = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Absorb one accepted record; on a final record work out the whole sorted set.
  // Rank of a record = records with a larger key + earlier records with the same key,
  // which keeps equal keys in load order.
  task automatic absorb_record(input record_req_t r);
    int slot [DEPTH];
    int place;
    sorted_rec_t s;
    if (held_cnt < DEPTH) begin
      held_key[held_cnt] = r.key;
      held_tag[held_cnt] = r.tag;
      held_cnt++;
    end else begin
      records_cut++;    // store full: drop the record, final or not
    end
    if (r.fin) begin
      for (int i = 0; i < held_cnt; i++) begin
        place = 0;
        for (int j = 0; j < held_cnt; j++) begin
          if (held_key[j] > held_key[i] || (held_key[j] == held_key[i] && j < i))
            place++;
        end
        slot[place] = i;
      end
      for (int p = 0; p < held_cnt; p++) begin
        s.key  = held_key[slot[p]];
        s.tag  = held_tag[slot[p]];
        s.rank = RANK_W'(p);
        s.eor  = (p == held_cnt - 1);
        sorted_due.push_back(s);
      end
      held_cnt = 0;
      sets_done++;
    end
  endtask

  // Draw a key: full random, a pool of near-equal values for ties, an extreme, or a small key near zero.
  function automatic logic signed [KEY_W-1:0] pick_key();
    int v;
    case ($urandom_range(0, 3))
      0: pick_key = $urandom;
      1: begin
        v = $urandom_range(0, 4);
        pick_key = (v - 2) * 65536;
      end
      2: begin
        case ($urandom_range(0, 3))
          0: pick_key = 32'sh7FFF_FFFF;
          1: pick_key = 32'sh8000_0000;
          2: pick_key = 32'sh0000_0000;
          default: pick_key = 32'shFFFF_FFFF;
        endcase
      end
      default: pick_key = $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
    endcase
  endfunction

  function automatic record_req_t mk_rec(input logic signed [KEY_W-1:0] k,
                                         input logic [TAG_W-1:0] t, input logic f);
    mk_rec.key = k;
    mk_rec.tag = t;
    mk_rec.fin = f;
  endfunction

  // Driver: offer backlog records, with random idle bursts while traffic is not in its tail.
  always @(posedge clk_i or negedge rst_ni) begin : drive_records
    logic take;
    record_req_t nxt;
    if (!rst_ni) begin
      rec_in.valid        <= 1'b0;
      rec_in.fitness_key  <= '0;
      rec_in.record_tag   <= '0;
      rec_in.final_record <= 1'b0;
      gap_left            <= 0;
      tail_phase          <= 1'b0;
      accepted_total      <= 0;
    end else begin
      take = rec_in.valid && rec_in.ready;
      if (take) begin
        nxt.key = rec_in.fitness_key;
        nxt.tag = rec_in.record_tag;
        nxt.fin = rec_in.final_record;
        absorb_record(nxt);
        accepted_total <= accepted_total + 1;
      end
      if (!rec_in.valid || take) begin
        if (gap_left > 0) begin
          gap_left     <= gap_left - 1;
          rec_in.valid <= 1'b0;
        end else if (record_backlog.size() > 0 && !tail_phase && !hold_rx &&
                     $urandom_range(0, 9) == 0) begin
          // Start a random idle gap, this cycle included.
          gap_left     <= $urandom_range(0, 18);
          rec_in.valid <= 1'b0;
        end else if (record_backlog.size() > 0) begin
          nxt = record_backlog.pop_front();
          rec_in.valid        <= 1'b1;
          rec_in.fitness_key  <= nxt.key;
          rec_in.record_tag   <= nxt.tag;
          rec_in.final_record <= nxt.fin;
          tail_phase          <= (record_backlog.size() < TAIL_ITEMS);
        end else begin
          rec_in.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once traffic is under way, so the sorter backs up its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_rx   <= 1'b0;
      hold_done <= 1'b0;
      hold_left <= 0;
    end else if (!hold_done && accepted_total >= 40) begin
      hold_rx   <= 1'b1;
      hold_done <= 1'b1;
      hold_left <= HOLD_CYC;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      if (hold_left == 1)
        hold_rx <= 1'b0;
    end
  end

  // Monitor: check each accepted sorted record against the oldest one owed, and drive ready.
  always @(posedge clk_i or negedge rst_ni) begin : check_sorted
    sorted_rec_t want;
    if (!rst_ni) begin
      rec_out.ready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (rec_out.valid && rec_out.ready) begin
        results_seen++;
        if (sorted_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected record key=%0d tag=%h rank=%0d end=%b", $time,
                   rec_out.sorted_key, rec_out.sorted_tag, rec_out.rank, rec_out.end_of_run);
        end else begin
          want = sorted_due.pop_front();
          if (rec_out.sorted_key !== want.key) begin
            errors++;
            $display("%0t: sorted_key expected %0d actual %0d", $time, want.key,
                     rec_out.sorted_key);
          end
          if (rec_out.sorted_tag !== want.tag) begin
            errors++;
            $display("%0t: sorted_tag expected %h actual %h", $time, want.tag,
                     rec_out.sorted_tag);
          end
          if (rec_out.rank !== want.rank) begin
            errors++;
            $display("%0t: rank expected %0d actual %0d", $time, want.rank, rec_out.rank);
          end
          if (rec_out.end_of_run !== want.eor) begin
            errors++;
            $display("%0t: end_of_run expected %b actual %b", $time, want.eor,
                     rec_out.end_of_run);
          end
        end
      end
      // Hold off for the long stretch, else stall in random bursts outside the tail phase.
      if (hold_rx) begin
        rec_out.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left    <= stall_left - 1;
        rec_out.ready <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
        stall_left    <= $urandom_range(0, 18);
        rec_out.ready <= 1'b0;
      end else begin
        rec_out.ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int len;
    int set_no;
    int rand_cnt;
    int wait_cnt;

    // Single record set at the top key and top tag.
    record_backlog.push_back(mk_rec(32'sh7FFF_FFFF, 16'hFFFF, 1'b1));
    // Extremes of the key, a tie on zero, tags from the bottom of the range.
    record_backlog.push_back(mk_rec(32'sh8000_0000, 16'h0000, 1'b0));
    record_backlog.push_back(mk_rec(32'sh0000_0000, 16'h0001, 1'b0));
    record_backlog.push_back(mk_rec(32'shFFFF_FFFF, 16'h0002, 1'b0));
    record_backlog.push_back(mk_rec(32'sh0001_0000, 16'h0003, 1'b0));
    record_backlog.push_back(mk_rec(32'sh0000_0000, 16'h0004, 1'b0));
    record_backlog.push_back(mk_rec(32'sh7FFF_FFFF, 16'h0005, 1'b0));
    record_backlog.push_back(mk_rec(32'sh8000_0000, 16'h0006, 1'b1));
    // All keys equal: output must follow load order.
    record_backlog.push_back(mk_rec(-32'sd1, 16'h00A0, 1'b0));
    record_backlog.push_back(mk_rec(-32'sd1, 16'h00A1, 1'b0));
    record_backlog.push_back(mk_rec(-32'sd1, 16'h00A2, 1'b1));

    // Random sets; every sixth one overruns the store so the tail and its final get dropped.
    set_no   = 0;
    rand_cnt = 0;
    while (rand_cnt < RAND_ITEMS) begin
      if (set_no % 6 == 5)
        len = $urandom_range(DEPTH + 1, DEPTH + 4);
      else
        len = $urandom_range(1, DEPTH);
      for (int i = 0; i < len; i++)
        record_backlog.push_back(mk_rec(pick_key(), TAG_W'($urandom_range(0, 16'hFFFF)),
                                        i == len - 1));
      rand_cnt += len;
      set_no++;
    end

    // Wait until every record is taken, then for the sorted output to drain.
    @(posedge rst_ni);
    while (record_backlog.size() != 0 || rec_in.valid)
      @(posedge clk_i);
    wait_cnt = 0;
    while (sorted_due.size() != 0 && wait_cnt < DRAIN_MAX) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (SETTLE) @(posedge clk_i);

    if (sorted_due.size() != 0) begin
      errors += sorted_due.size();
      $display("%0t: %0d sorted records never arrived, first expected key=%0d tag=%h",
               $time, sorted_due.size(), sorted_due[0].key, sorted_due[0].tag);
    end

    $display("Sorted %0d record sets (%0d records checked), %0d records dropped at full store,",
             sets_done, results_seen, records_cut);
    $display("including ties, key extremes and a %0d-cycle output hold-off.", HOLD_CYC);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/dkrs_pkg.sv
sv/dkrs_if.sv
sv/dkrs_cell.sv
sv/descending_key_record_sorter.sv
test/testbench.sv
